/* hdl/rec_pkg.sv */
// ----------------------------------------------------------------------------
// rec_pkg: shared types and constants of the ray extend and clip core
// transaction structs, register indexes, frame size and divider sizing
// ----------------------------------------------------------------------------
package rec_pkg;

   // frame size in pixels
   localparam int FRAME_W = 320;
   localparam int FRAME_H = 240;

   // frame edges as 17 bit signed values for compares against the ray end
   localparam logic signed [16:0] FRAME_W_D = 17'(FRAME_W);
   localparam logic signed [16:0] FRAME_H_D = 17'(FRAME_H);

   // configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_ACC_THRESHOLD = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_EXTEND_HALVES = 1'b1;

   localparam logic [15:0] ACC_THRESHOLD_RESET = 16'd30;
   localparam logic [3:0]  EXTEND_HALVES_RESET = 4'd3;

   // divider: numerator magnitude, divisor magnitude, two quotient bits a cycle
   localparam int NUM_W     = 28;
   localparam int DEN_W     = 10;
   localparam int DIV_STEPS = NUM_W / 2;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   typedef enum logic [2:0] {
      EDGE_NONE   = 3'd0,
      EDGE_TOP    = 3'd1,
      EDGE_RIGHT  = 3'd2,
      EDGE_BOTTOM = 3'd3,
      EDGE_LEFT   = 3'd4
   } clip_edge_type;

   typedef struct packed {
      logic [9:0]  from_x;
      logic [9:0]  from_y;
      logic [15:0] from_accuracy;
      logic [9:0]  to_x;
      logic [9:0]  to_y;
      logic [15:0] to_accuracy;
   } req_type;

   typedef struct packed {
      logic [9:0]         line_start_x;
      logic [9:0]         line_start_y;
      logic signed [15:0] ray_end_x;
      logic signed [15:0] ray_end_y;
      clip_edge_type      clip_edge;
   } rsp_type;

endpackage

/* hdl/ray_extend_and_clip_core.sv */
// ----------------------------------------------------------------------------
// ray_extend_and_clip_core: ray extender with one-edge frame clipping
// keeps tracked points above an accuracy threshold, extends the ray between
// them and clips its end against the first frame edge that it crosses
// ----------------------------------------------------------------------------
// One request transaction gives one response transaction. A transaction that
// needs the exact slope (the end is clipped and the line is not vertical, or
// for top and bottom not horizontal) passes these states from acceptance
// until the next request can be accepted: ST_CALC forms the extended end and
// picks the edge, ST_MUL and ST_SUM form the 16x11 and 17x11 products,
// ST_DIV runs the restoring divider, which retires two quotient bits a cycle
// over the 28 bit numerator, ST_FIN saturates and loads the response
// register, and ST_IDLE takes the next request. Every other transaction
// goes from ST_CALC straight to ST_FIN. The response register decouples the
// two sides: the next request is accepted and worked on while a finished
// response still waits under rsp_stall; a second result that finishes while
// the first still waits holds in the finish state until the register drains.
// Points are kept when their accuracy is strictly above register 0; the
// first pair after reset is always kept.
// Register 1 sets the extension in halves of the point difference.
// ----------------------------------------------------------------------------
module ray_extend_and_clip_core (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  rec_pkg::req_type                req_data,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output rec_pkg::rsp_type                rsp_data,
   // configuration writes
   input  logic                            csr_write_en,
   input  logic [rec_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rec_pkg::CSR_DATA_W-1:0]  csr_data
);

   // sequencer
   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_CALC = 6'b000010,
      ST_MUL  = 6'b000100,
      ST_SUM  = 6'b001000,
      ST_DIV  = 6'b010000,
      ST_FIN  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic [15:0] acc_threshold_ff, acc_threshold_in;
   logic [3:0]  extend_halves_ff, extend_halves_in;

   // kept points
   logic [9:0] kept_from_x_ff, kept_from_x_in;
   logic [9:0] kept_from_y_ff, kept_from_y_in;
   logic [9:0] kept_to_x_ff,   kept_to_x_in;
   logic [9:0] kept_to_y_ff,   kept_to_y_in;
   logic       first_pending_ff, first_pending_in;

   // end point and clip operands
   logic signed [15:0]    end_x_ff, end_x_in;
   logic signed [15:0]    end_y_ff, end_y_in;
   rec_pkg::clip_edge_type edge_ff, edge_in;
   logic                  need_div_ff, need_div_in;
   logic                  div_to_y_ff, div_to_y_in;
   logic signed [15:0]    base_ff, base_in;
   logic signed [16:0]    delta_ff, delta_in;
   logic signed [10:0]    num_ff, num_in;
   logic signed [10:0]    den_ff, den_in;
   logic signed [26:0]    prod_ff, prod_in;

   // divider
   logic [rec_pkg::NUM_W-1:0]     div_sr_ff, div_sr_in;
   logic [rec_pkg::DEN_W-1:0]     rem_ff, rem_in;
   logic [rec_pkg::DEN_W-1:0]     den_mag_ff, den_mag_in;
   logic                          quo_neg_ff, quo_neg_in;
   logic [rec_pkg::DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;

   // response register
   logic             rsp_valid_ff, rsp_valid_in;
   rec_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // combinational helpers
   logic               req_take;
   logic               rsp_load;
   logic signed [10:0] dx_c, dy_c;
   logic signed [15:0] kdx_c, kdy_c;
   logic signed [16:0] sum_x_c, sum_y_c;
   logic [16:0]        adj_x_c, adj_y_c;
   logic signed [15:0] ex_c, ey_c;
   logic signed [16:0] ex_d, ey_d;
   logic signed [27:0] dn_c;
   logic signed [28:0] numer_c;
   logic [28:0]        numer_abs_c;
   logic [rec_pkg::DEN_W:0] step1_c, step2_c;
   logic signed [15:0] quo_sat_c;

   // one restoring step: {quotient bit, new remainder}
   function automatic logic [rec_pkg::DEN_W:0] div_step(
      input logic [rec_pkg::DEN_W-1:0] rem,
      input logic                      nbit,
      input logic [rec_pkg::DEN_W-1:0] d
   );
      logic [rec_pkg::DEN_W:0] t;
      logic [rec_pkg::DEN_W:0] diff;
      t    = {rem, nbit};
      diff = t - {1'b0, d};
      if (t >= {1'b0, d}) begin
         div_step = {1'b1, diff[rec_pkg::DEN_W-1:0]};
      end else begin
         div_step = {1'b0, t[rec_pkg::DEN_W-1:0]};
      end
   endfunction

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_load  = (state_ff == ST_FIN) && (!rsp_valid_ff || !rsp_stall);

   // extended end point from the kept points
   assign dx_c    = $signed({1'b0, kept_to_x_ff}) - $signed({1'b0, kept_from_x_ff});
   assign dy_c    = $signed({1'b0, kept_to_y_ff}) - $signed({1'b0, kept_from_y_ff});
   assign kdx_c   = $signed({1'b0, extend_halves_ff}) * dx_c;
   assign kdy_c   = $signed({1'b0, extend_halves_ff}) * dy_c;
   assign sum_x_c = $signed({6'b0, kept_to_x_ff, 1'b0}) + $signed({kdx_c[15], kdx_c});
   assign sum_y_c = $signed({6'b0, kept_to_y_ff, 1'b0}) + $signed({kdy_c[15], kdy_c});
   // halve toward zero: bias negative sums by one before the shift
   assign adj_x_c = sum_x_c + {16'b0, sum_x_c[16]};
   assign adj_y_c = sum_y_c + {16'b0, sum_y_c[16]};
   assign ex_c    = $signed(adj_x_c[16:1]);
   assign ey_c    = $signed(adj_y_c[16:1]);
   assign ex_d    = $signed({ex_c[15], ex_c});
   assign ey_d    = $signed({ey_c[15], ey_c});

   // base*den + delta*num, then sign and magnitude for the divider
   assign dn_c        = delta_ff * num_ff;
   assign numer_c     = prod_ff + dn_c;
   assign numer_abs_c = numer_c[28] ? 29'(-numer_c) : numer_c;

   // two quotient bits a cycle
   assign step1_c = div_step(rem_ff, div_sr_ff[rec_pkg::NUM_W-1], den_mag_ff);
   assign step2_c = div_step(step1_c[rec_pkg::DEN_W-1:0], div_sr_ff[rec_pkg::NUM_W-2],
                             den_mag_ff);

   // saturate the signed quotient to 16 bits
   always_comb begin
      if (quo_neg_ff) begin
         if (div_sr_ff > rec_pkg::NUM_W'(32768)) begin
            quo_sat_c = 16'sh8000;
         end else begin
            quo_sat_c = 16'(-$signed({1'b0, div_sr_ff[15:0]}));
         end
      end else begin
         if (div_sr_ff > rec_pkg::NUM_W'(32767)) begin
            quo_sat_c = 16'sh7fff;
         end else begin
            quo_sat_c = $signed(div_sr_ff[15:0]);
         end
      end
   end

   always_comb begin
      state_in         = state_ff;
      acc_threshold_in = acc_threshold_ff;
      extend_halves_in = extend_halves_ff;
      kept_from_x_in   = kept_from_x_ff;
      kept_from_y_in   = kept_from_y_ff;
      kept_to_x_in     = kept_to_x_ff;
      kept_to_y_in     = kept_to_y_ff;
      first_pending_in = first_pending_ff;
      end_x_in         = end_x_ff;
      end_y_in         = end_y_ff;
      edge_in          = edge_ff;
      need_div_in      = need_div_ff;
      div_to_y_in      = div_to_y_ff;
      base_in          = base_ff;
      delta_in         = delta_ff;
      num_in           = num_ff;
      den_in           = den_ff;
      prod_in          = prod_ff;
      div_sr_in        = div_sr_ff;
      rem_in           = rem_ff;
      den_mag_in       = den_mag_ff;
      quo_neg_in       = quo_neg_ff;
      div_cnt_in       = div_cnt_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_data_in      = rsp_data_ff;

      // configuration writes
      if (csr_write_en) begin
         unique case (csr_index)
            rec_pkg::CSR_ACC_THRESHOLD: acc_threshold_in = csr_data[15:0];
            rec_pkg::CSR_EXTEND_HALVES: extend_halves_in = csr_data[3:0];
            default: ;
         endcase
      end

      // response drains
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               // accuracy gate, first pair always taken
               if (first_pending_ff || (req_data.from_accuracy > acc_threshold_ff)) begin
                  kept_from_x_in = req_data.from_x;
                  kept_from_y_in = req_data.from_y;
               end
               if (first_pending_ff || (req_data.to_accuracy > acc_threshold_ff)) begin
                  kept_to_x_in = req_data.to_x;
                  kept_to_y_in = req_data.to_y;
               end
               first_pending_in = 1'b0;
               state_in         = ST_CALC;
            end
         end
         ST_CALC: begin
            // edge test order: top, right, bottom, left
            end_x_in    = ex_c;
            end_y_in    = ey_c;
            edge_in     = rec_pkg::EDGE_NONE;
            need_div_in = 1'b0;
            div_to_y_in = 1'b0;
            base_in     = ex_c;
            delta_in    = -ey_d;
            num_in      = dx_c;
            den_in      = dy_c;
            if (ey_c[15]) begin
               edge_in     = rec_pkg::EDGE_TOP;
               end_y_in    = 16'sd0;
               need_div_in = (dx_c != 11'sd0) && (dy_c != 11'sd0);
            end else if (ex_d > rec_pkg::FRAME_W_D) begin
               edge_in     = rec_pkg::EDGE_RIGHT;
               end_x_in    = 16'(rec_pkg::FRAME_W_D);
               need_div_in = (dx_c != 11'sd0);
               div_to_y_in = 1'b1;
               base_in     = ey_c;
               delta_in    = rec_pkg::FRAME_W_D - ex_d;
               num_in      = dy_c;
               den_in      = dx_c;
            end else if (ey_d > rec_pkg::FRAME_H_D) begin
               edge_in     = rec_pkg::EDGE_BOTTOM;
               end_y_in    = 16'(rec_pkg::FRAME_H_D);
               need_div_in = (dx_c != 11'sd0) && (dy_c != 11'sd0);
               delta_in    = rec_pkg::FRAME_H_D - ey_d;
            end else if (ex_c[15]) begin
               edge_in     = rec_pkg::EDGE_LEFT;
               end_x_in    = 16'sd0;
               need_div_in = (dx_c != 11'sd0);
               div_to_y_in = 1'b1;
               base_in     = ey_c;
               delta_in    = -ex_d;
               num_in      = dy_c;
               den_in      = dx_c;
            end
            if (ey_c[15] || (ex_d > rec_pkg::FRAME_W_D) ||
                (ey_d > rec_pkg::FRAME_H_D) || ex_c[15]) begin
               if ((dx_c != 11'sd0) &&
                   ((dy_c != 11'sd0) || (ex_d > rec_pkg::FRAME_W_D) ||
                    (!ey_c[15] && !(ey_d > rec_pkg::FRAME_H_D)))) begin
                  state_in = ST_MUL;
               end else begin
                  state_in = ST_FIN;
               end
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_MUL: begin
            prod_in  = base_ff * den_ff;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            div_sr_in  = numer_abs_c[rec_pkg::NUM_W-1:0];
            rem_in     = '0;
            den_mag_in = den_ff[10] ? 10'(-den_ff) : den_ff[9:0];
            quo_neg_in = numer_c[28] ^ den_ff[10];
            div_cnt_in = '0;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            div_sr_in  = {div_sr_ff[rec_pkg::NUM_W-3:0],
                          step1_c[rec_pkg::DEN_W], step2_c[rec_pkg::DEN_W]};
            rem_in     = step2_c[rec_pkg::DEN_W-1:0];
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == rec_pkg::DIV_CNT_W'(rec_pkg::DIV_STEPS - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (rsp_load) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.line_start_x  = kept_to_x_ff;
               rsp_data_in.line_start_y  = kept_to_y_ff;
               rsp_data_in.ray_end_x     = end_x_ff;
               rsp_data_in.ray_end_y     = end_y_ff;
               rsp_data_in.clip_edge     = edge_ff;
               if (need_div_ff && div_to_y_ff) begin
                  rsp_data_in.ray_end_y = quo_sat_c;
               end else if (need_div_ff) begin
                  rsp_data_in.ray_end_x = quo_sat_c;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         acc_threshold_ff <= rec_pkg::ACC_THRESHOLD_RESET;
         extend_halves_ff <= rec_pkg::EXTEND_HALVES_RESET;
         kept_from_x_ff   <= '0;
         kept_from_y_ff   <= '0;
         kept_to_x_ff     <= '0;
         kept_to_y_ff     <= '0;
         first_pending_ff <= 1'b1;
         rsp_valid_ff     <= 1'b0;
         div_cnt_ff       <= '0;
      end else begin
         state_ff         <= state_in;
         acc_threshold_ff <= acc_threshold_in;
         extend_halves_ff <= extend_halves_in;
         kept_from_x_ff   <= kept_from_x_in;
         kept_from_y_ff   <= kept_from_y_in;
         kept_to_x_ff     <= kept_to_x_in;
         kept_to_y_ff     <= kept_to_y_in;
         first_pending_ff <= first_pending_in;
         rsp_valid_ff     <= rsp_valid_in;
         div_cnt_ff       <= div_cnt_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      end_x_ff    <= end_x_in;
      end_y_ff    <= end_y_in;
      edge_ff     <= edge_in;
      need_div_ff <= need_div_in;
      div_to_y_ff <= div_to_y_in;
      base_ff     <= base_in;
      delta_ff    <= delta_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
      prod_ff     <= prod_in;
      div_sr_ff   <= div_sr_in;
      rem_ff      <= rem_in;
      den_mag_ff  <= den_mag_in;
      quo_neg_ff  <= quo_neg_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   // divider never runs on a zero divisor
   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (den_mag_ff != '0))
      else $error("divider running with zero divisor");

   // divider leaves after the last step
   a_div_length: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DIV) &&
       (div_cnt_ff == rec_pkg::DIV_CNT_W'(rec_pkg::DIV_STEPS - 1))) |=> (state_ff == ST_FIN))
      else $error("divider step count wrong");

   // a new response only comes from the finish state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FIN))
      else $error("response raised outside finish state");

   // a finished result waits while the response register is blocked
   a_fin_hold: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_FIN) && rsp_valid_ff && rsp_stall) |=>
      ((state_ff == ST_FIN) && rsp_valid_ff))
      else $error("finished result overwrote pending response");
`endif

endmodule
